FILE: hdl/pce_pkg.sv
package pce_pkg;

   // Widths of the configuration registers and of the frame position.
   localparam int GEN_W       = 28;
   localparam int PAT_W       = 32;
   localparam int PER_W       = 4;
   localparam int TAIL_W      = 24;
   localparam int IDX_W       = 16;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // Lanes carried per step record; steps with fewer outputs leave the rest clear.
   localparam int LANES       = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [IDX_W-1:0] INDEX_MAX = '1;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_GEN_POLYS    = 3'd0;
   localparam logic [2:0] REG_PATTERN_A    = 3'd1;
   localparam logic [2:0] REG_PERIOD_A     = 3'd2;
   localparam logic [2:0] REG_PATTERN_B    = 3'd3;
   localparam logic [2:0] REG_PERIOD_B     = 3'd4;
   localparam logic [2:0] REG_TAIL_PATTERN = 3'd5;
   localparam logic [2:0] REG_PART_A_BITS  = 3'd6;
   localparam logic [2:0] REG_FAC_MODE     = 3'd7;

   typedef struct packed {
      logic [GEN_W-1:0]  generator_polys;
      logic [PAT_W-1:0]  pattern_a;
      logic [PER_W-1:0]  period_a;
      logic [PAT_W-1:0]  pattern_b;
      logic [PER_W-1:0]  period_b;
      logic [TAIL_W-1:0] tail_pattern;
      logic [IDX_W-1:0]  part_a_bits;
      logic              fac_mode;
   } csr_type;

   // One encoder step: parities, which of them survive puncturing, frame end.
   // Closing marks the data step of a frame-ending item and all of its tail steps.
   typedef struct packed {
      logic             closing;
      logic             last;
      logic [LANES-1:0] parity;
      logic [LANES-1:0] keep;
   } step_type;

   // A period of zero behaves as one, and anything above the maximum as the maximum.
   function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p,
                                                   input logic [PER_W-1:0] max_p);
      logic [PER_W-1:0] r;
      if (p == '0) begin
         r = PER_W'(1);
      end else if (p > max_p) begin
         r = max_p;
      end else begin
         r = p;
      end
      return r;
   endfunction

endpackage

FILE: hdl/pce_queue.sv
module pce_queue
   import pce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  step_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output step_type pop_data
);

   localparam int QA = $clog2(QUEUE_DEPTH);

   step_type        store_ff [QUEUE_DEPTH];
   logic [QA:0]     wr_ptr_ff;
   logic [QA:0]     rd_ptr_ff;

   // Pointers carry one extra bit to tell a full queue from an empty one.
   assign full      = (wr_ptr_ff[QA] != rd_ptr_ff[QA]) &&
                      (wr_ptr_ff[QA-1:0] == rd_ptr_ff[QA-1:0]);
   assign pop_valid = (wr_ptr_ff != rd_ptr_ff);
   assign pop_data  = store_ff[rd_ptr_ff[QA-1:0]];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         store_ff[wr_ptr_ff[QA-1:0]] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && pop_valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

FILE: hdl/pce_front.sv
module pce_front
   import pce_pkg::*;
#(
   parameter int CONSTRAINT_LEN   = 7,
   parameter int OUTPUTS_PER_STEP = 4,
   parameter int MAX_PERIOD       = 8
)
(
   input  logic     clock,
   input  logic     reset,
   input  csr_type  cfg,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     data_bit,
   input  logic     frame_last,
   output logic     step_push,
   output step_type step_data,
   input  logic     queue_full
);

   localparam int TAIL_STEPS = CONSTRAINT_LEN - 1;
   localparam int TW         = (TAIL_STEPS > 2) ? $clog2(TAIL_STEPS) : 1;
   localparam int POLY_W     = GEN_W + CONSTRAINT_LEN * LANES;

   localparam logic ST_DATA = 1'b0;
   localparam logic ST_TAIL = 1'b1;

   logic                      state_ff;
   logic [TW-1:0]             tail_cnt_ff;
   logic                      ended_in_a_ff;
   logic [CONSTRAINT_LEN-1:0] shift_ff;
   logic [PER_W-1:0]          period_count_ff;
   logic [PAT_W-1:0]          mask_ff;
   logic [IDX_W-1:0]          bit_index_ff;

   logic                      in_tail;
   logic                      step_go;
   logic                      advance;
   logic                      in_a;
   logic                      enter_b;
   logic                      last_step;
   logic [PER_W-1:0]          per;
   logic [PER_W-1:0]          pc_start;
   logic [PER_W-1:0]          pc_inc;
   logic [PER_W-1:0]          period_count_in;
   logic [PAT_W-1:0]          mask_sel;
   logic [CONSTRAINT_LEN-1:0] shift_in;
   logic [POLY_W-1:0]         polys_wide;
   logic [IDX_W-1:0]          bit_index_in;

   // Items enter only between frames' tails and while the queue has room.
   assign in_tail    = (state_ff == ST_TAIL);
   assign req_tready = !in_tail && !queue_full;
   assign step_go    = !queue_full && (in_tail || req_tvalid);
   assign last_step  = in_tail && (tail_cnt_ff == TW'(TAIL_STEPS - 1));
   assign polys_wide = {{(CONSTRAINT_LEN * LANES){1'b0}}, cfg.generator_polys};

   // Classify the step: part A, part B, or a tail step of either kind.
   always_comb begin
      advance = !in_tail || cfg.fac_mode;
      in_a    = !in_tail && (bit_index_ff < cfg.part_a_bits);
      enter_b = ((bit_index_ff == cfg.part_a_bits) && (bit_index_ff != INDEX_MAX)) ||
                (in_tail && (tail_cnt_ff == '0) && ended_in_a_ff);
      per     = in_a ? eff_period(cfg.period_a, PER_W'(MAX_PERIOD))
                     : eff_period(cfg.period_b, PER_W'(MAX_PERIOD));
      pc_start = (!in_a && enter_b) ? '0 : period_count_ff;
      pc_inc   = pc_start + 1'b1;
      period_count_in = (pc_inc >= per) ? '0 : pc_inc;
      if (advance) begin
         if (pc_start == '0) begin
            mask_sel = in_a ? cfg.pattern_a : cfg.pattern_b;
         end else begin
            mask_sel = mask_ff;
         end
      end else if (tail_cnt_ff == '0) begin
         mask_sel = PAT_W'(cfg.tail_pattern);
      end else begin
         mask_sel = mask_ff;
      end
      bit_index_in = (bit_index_ff == INDEX_MAX) ? bit_index_ff : bit_index_ff + 1'b1;
   end

   // New encoder state and the parities formed from it.
   always_comb begin
      shift_in = {shift_ff[CONSTRAINT_LEN-2:0], (!in_tail && data_bit)};
      step_data = '0;
      step_data.closing = in_tail || frame_last;
      step_data.last = last_step;
      for (int k = 0; k < LANES; k++) begin
         if (k < OUTPUTS_PER_STEP) begin
            step_data.parity[k] = ^(shift_in & polys_wide[CONSTRAINT_LEN*k +: CONSTRAINT_LEN]);
            step_data.keep[k]   = mask_sel[k];
         end
      end
   end

   assign step_push = step_go;

   // Step state; everything clears once the last tail step has gone out.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_DATA;
         tail_cnt_ff     <= '0;
         ended_in_a_ff   <= 1'b0;
         shift_ff        <= '0;
         period_count_ff <= '0;
         mask_ff         <= '0;
         bit_index_ff    <= '0;
      end else if (step_go) begin
         if (last_step) begin
            state_ff        <= ST_DATA;
            tail_cnt_ff     <= '0;
            ended_in_a_ff   <= 1'b0;
            shift_ff        <= '0;
            period_count_ff <= '0;
            mask_ff         <= '0;
            bit_index_ff    <= '0;
         end else begin
            shift_ff <= shift_in;
            mask_ff  <= mask_sel >> OUTPUTS_PER_STEP;
            if (advance) begin
               period_count_ff <= period_count_in;
               bit_index_ff    <= bit_index_in;
            end
            if (in_tail) begin
               tail_cnt_ff <= tail_cnt_ff + 1'b1;
            end else if (frame_last) begin
               state_ff      <= ST_TAIL;
               tail_cnt_ff   <= '0;
               ended_in_a_ff <= in_a;
            end
         end
      end
   end

endmodule

FILE: hdl/pce_back.sv
module pce_back
   import pce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step_valid,
   input  step_type step_data,
   output logic     step_pop,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output logic     coded_bit,
   output logic     frame_end
);

   logic             cur_valid_ff;
   step_type         cur_ff;
   logic             pend_valid_ff;
   logic             pend_bit_ff;
   logic             out_valid_ff;
   logic             out_bit_ff;
   logic             out_end_ff;

   logic             out_free;
   logic             hold_ok;
   logic             has_keep;
   logic [LANES-1:0] low_sel;
   logic [LANES-1:0] keep_rest;
   logic             pick_bit;
   logic             take;
   logic             direct;
   logic             flush;
   logic             retire;
   logic             load;
   logic             emit;

   // Lowest surviving lane of the current step goes next. Bits of ordinary steps go
   // straight out; bits of a frame's closing steps pass through the hold register.
   always_comb begin
      out_free  = !out_valid_ff || rsp_tready;
      hold_ok   = !pend_valid_ff || out_free;
      has_keep  = (cur_ff.keep != '0);
      low_sel   = cur_ff.keep & (~cur_ff.keep + 1'b1);
      keep_rest = cur_ff.keep & ~low_sel;
      pick_bit  = |(low_sel & cur_ff.parity);
      take      = cur_valid_ff && has_keep && (cur_ff.closing ? hold_ok : out_free);
      direct    = take && !cur_ff.closing;
      flush     = cur_valid_ff && !has_keep && cur_ff.last && hold_ok;
      retire    = (cur_valid_ff && !has_keep && !cur_ff.last) || flush ||
                  (take && (keep_rest == '0) && !cur_ff.last);
      load      = step_valid && (!cur_valid_ff || retire);
      emit      = direct || (pend_valid_ff && (take || flush));
   end

   assign step_pop = load;

   // Current step record.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else if (load) begin
         cur_valid_ff <= 1'b1;
      end else if (retire) begin
         cur_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= step_data;
      end else if (take) begin
         cur_ff.keep <= keep_rest;
      end
   end

   // Within the closing steps one bit is held back until it is known whether the
   // frame ends on it.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (take && cur_ff.closing) begin
         pend_valid_ff <= 1'b1;
      end else if (flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && cur_ff.closing) begin
         pend_bit_ff <= pick_bit;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_bit_ff <= direct ? pick_bit : pend_bit_ff;
         out_end_ff <= flush;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign coded_bit  = out_bit_ff;
   assign frame_end  = out_end_ff;

endmodule

FILE: hdl/punctured_conv_encoder.sv
// Channel  Direction  Payload
// req_     in         tdata[0] data_bit, tlast frame_last
// rsp_     out        tdata[0] coded_bit, tlast frame_end
// csr_     in/out     APB-style registers at byte address 4*index
//
// The front step unit turns each item into one step record; the back part sends at most one
// coded bit a cycle while rsp_tready holds, and an item yields as many bits as it keeps parity
// bits, four at most. A frame-ending item adds six tail steps, during which the input is held
// off, and the final bit of the frame is marked through the hold register.
// Reset is synchronous and clears the encoder state, the step queue and the output register.
// Either side may stall on its own: the four-entry step queue decouples them.
module punctured_conv_encoder
   import pce_pkg::*;
#(
   parameter int CONSTRAINT_LEN   = 7,
   parameter int OUTPUTS_PER_STEP = 4,
   parameter int MAX_PERIOD       = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] data_bit
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] coded_bit
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   csr_type     cfg_ff;
   logic        csr_write;
   logic [2:0]  reg_index;
   logic        step_push;
   step_type    push_data;
   logic        queue_full;
   logic        step_pop;
   logic        step_valid;
   step_type    pop_data;
   logic        coded_bit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator_polys <= '0;
         cfg_ff.pattern_a       <= '0;
         cfg_ff.period_a        <= PER_W'(1);
         cfg_ff.pattern_b       <= '0;
         cfg_ff.period_b        <= PER_W'(1);
         cfg_ff.tail_pattern    <= '0;
         cfg_ff.part_a_bits     <= '0;
         cfg_ff.fac_mode        <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_GEN_POLYS:    cfg_ff.generator_polys <= csr_pwdata[GEN_W-1:0];
            REG_PATTERN_A:    cfg_ff.pattern_a       <= csr_pwdata[PAT_W-1:0];
            REG_PERIOD_A:     cfg_ff.period_a        <= csr_pwdata[PER_W-1:0];
            REG_PATTERN_B:    cfg_ff.pattern_b       <= csr_pwdata[PAT_W-1:0];
            REG_PERIOD_B:     cfg_ff.period_b        <= csr_pwdata[PER_W-1:0];
            REG_TAIL_PATTERN: cfg_ff.tail_pattern    <= csr_pwdata[TAIL_W-1:0];
            REG_PART_A_BITS:  cfg_ff.part_a_bits     <= csr_pwdata[IDX_W-1:0];
            REG_FAC_MODE:     cfg_ff.fac_mode        <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (reg_index)
         REG_GEN_POLYS:    csr_prdata = CSR_DATA_W'(cfg_ff.generator_polys);
         REG_PATTERN_A:    csr_prdata = CSR_DATA_W'(cfg_ff.pattern_a);
         REG_PERIOD_A:     csr_prdata = CSR_DATA_W'(cfg_ff.period_a);
         REG_PATTERN_B:    csr_prdata = CSR_DATA_W'(cfg_ff.pattern_b);
         REG_PERIOD_B:     csr_prdata = CSR_DATA_W'(cfg_ff.period_b);
         REG_TAIL_PATTERN: csr_prdata = CSR_DATA_W'(cfg_ff.tail_pattern);
         REG_PART_A_BITS:  csr_prdata = CSR_DATA_W'(cfg_ff.part_a_bits);
         REG_FAC_MODE:     csr_prdata = CSR_DATA_W'(cfg_ff.fac_mode);
         default:          csr_prdata = '0;
      endcase
   end

   pce_front #(
      .CONSTRAINT_LEN   (CONSTRAINT_LEN),
      .OUTPUTS_PER_STEP (OUTPUTS_PER_STEP),
      .MAX_PERIOD       (MAX_PERIOD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .data_bit   (req_tdata[0]),
      .frame_last (req_tlast),
      .step_push  (step_push),
      .step_data  (push_data),
      .queue_full (queue_full)
   );

   pce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (step_pop),
      .pop_valid (step_valid),
      .pop_data  (pop_data)
   );

   pce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step_data  (pop_data),
      .step_pop   (step_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .coded_bit  (coded_bit),
      .frame_end  (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, coded_bit};

endmodule
